// ===== hdl/cgdp_pkg.sv =====
// ----------------------------------------------------------------------------
// cgdp_pkg
// Shared types, constants and helpers for the chaos game density plotter.
// ----------------------------------------------------------------------------
package cgdp_pkg;

  // grid and number formats
  localparam int GRID_ROWS  = 64;
  localparam int GRID_COLS  = 256;
  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS  = 16;

  localparam int ROW_W      = 6;
  localparam int COL_W      = 8;
  localparam int LEVEL_W    = 3;
  localparam int SEL_W      = 2;
  localparam int ROW_IDX_W  = $clog2(GRID_ROWS);
  localparam int COL_IDX_W  = $clog2(GRID_COLS);
  localparam int ADDR_W     = ROW_IDX_W + COL_IDX_W;
  localparam int HIST_DEPTH = GRID_ROWS * GRID_COLS;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_V0X  = 3'd0,
    REG_V0Y  = 3'd1,
    REG_V1X  = 3'd2,
    REG_V1Y  = 3'd3,
    REG_V2X  = 3'd4,
    REG_V2Y  = 3'd5,
    REG_ROWL = 3'd6,
    REG_COLL = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    FUNC_PLOT = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  typedef enum logic [SEL_W-1:0] {
    SEL_V0   = 2'd0,
    SEL_V1   = 2'd1,
    SEL_V2   = 2'd2,
    SEL_NONE = 2'd3
  } vsel_e;

  // configuration register set
  typedef struct packed {
    logic [2:0][FRAC_BITS-1:0] vx;
    logic [2:0][FRAC_BITS-1:0] vy;
    logic [ROW_W-1:0]          row_limit;
    logic [COL_W-1:0]          col_limit;
  } cfg_t;

  typedef struct packed {
    logic             func;
    logic [SEL_W-1:0] vertex_select;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]      cell_row;
    logic [COL_W-1:0]      cell_col;
    logic [COUNT_BITS-1:0] cell_count;
    logic [LEVEL_W-1:0]    density_level;
  } out_item_t;

  // level: 0 when empty, else 1 + min(4, floor(4*count/peak)); peak zero gives 5
  function automatic logic [LEVEL_W-1:0] level_of(logic [COUNT_BITS-1:0] count,
                                                  logic [COUNT_BITS-1:0] peak);
    logic [COUNT_BITS+1:0] c4;
    logic [COUNT_BITS+1:0] p1;
    logic [COUNT_BITS+1:0] p2;
    logic [COUNT_BITS+1:0] p3;
    logic [COUNT_BITS+1:0] p4;
    logic [LEVEL_W-1:0]    lvl;
    c4  = {count, 2'b00};
    p1  = {2'b00, peak};
    p2  = {1'b0, peak, 1'b0};
    p3  = p1 + p2;
    p4  = {peak, 2'b00};
    lvl = LEVEL_W'(1) + LEVEL_W'(c4 >= p1) + LEVEL_W'(c4 >= p2)
        + LEVEL_W'(c4 >= p3) + LEVEL_W'(c4 >= p4);
    if (count == '0) begin
      lvl = '0;
    end
    return lvl;
  endfunction

endpackage

// ===== hdl/cgdp_if.sv =====
// ----------------------------------------------------------------------------
// cgdp_in_if / cgdp_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface cgdp_in_if import cgdp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cgdp_out_if import cgdp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/chaos_game_density_plotter_core.sv =====
// Flow: an accepted input beat passes the read, modify and level steps, and then
//   the output register; a stalled output holds the block in its last step.
// One item at a time: input ready returns only once the last result is loaded.
// Reset: the histogram RAM is cleared by a pass over all 16384 cells, one cell a cycle;
//   input ready stays low until it ends. Config writes are taken throughout.
// ----------------------------------------------------------------------------
// chaos_game_density_plotter_core
// Chaos game cursor with a saturating hit-count histogram and density levels.
// ----------------------------------------------------------------------------
module chaos_game_density_plotter_core import cgdp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cgdp_in_if.sink               in_i,
  cgdp_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  typedef enum logic [4:0] {
    S_CLR  = 5'b00001,
    S_IDLE = 5'b00010,
    S_READ = 5'b00100,
    S_MOD  = 5'b01000,
    S_LVL  = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  cfg_t                  cfg;
  logic [ADDR_W-1:0]     clr_cnt_q;
  logic                  loaded_q;
  logic [FRAC_BITS-1:0]  cur_x_q, cur_y_q;
  logic [COUNT_BITS-1:0] peak_q;
  logic                  func_q;
  logic [SEL_W-1:0]      sel_q;
  logic [ROW_W-1:0]      row_q;
  logic [COL_W-1:0]      col_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  out_valid_q;
  out_item_t             out_data_q;

  logic                  in_acc;
  logic                  out_load;
  logic [FRAC_BITS-1:0]  eff_x, eff_y;
  logic [FRAC_BITS+ROW_W-1:0] prod_r;
  logic [FRAC_BITS+COL_W-1:0] prod_c;
  logic [ROW_W-1:0]      plot_row;
  logic [COL_W-1:0]      plot_col;
  logic [COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]     cell_addr;
  logic [FRAC_BITS-1:0]  tgt_x, tgt_y;
  logic                  do_move;
  logic [FRAC_BITS:0]    sum_x, sum_y;

  cgdp_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_load = (state_q == S_LVL) && (!out_valid_q || out_o.ready);

  // cursor in effect: vertex 0 before the first plot
  assign eff_x = loaded_q ? cur_x_q : cfg.vx[0];
  assign eff_y = loaded_q ? cur_y_q : cfg.vy[0];

  // scale cursor to a grid cell, truncate, clamp to the grid
  always_comb begin
    prod_r   = eff_y * cfg.row_limit;
    prod_c   = eff_x * cfg.col_limit;
    plot_row = prod_r[FRAC_BITS +: ROW_W];
    plot_col = prod_c[FRAC_BITS +: COL_W];
    if (plot_row > ROW_W'(GRID_ROWS - 1)) begin
      plot_row = ROW_W'(GRID_ROWS - 1);
    end
    if (plot_col > COL_W'(GRID_COLS - 1)) begin
      plot_col = COL_W'(GRID_COLS - 1);
    end
  end

  assign cell_addr = {row_q[ROW_IDX_W-1:0], col_q[COL_IDX_W-1:0]};

  // saturating increment for plots, plain pass for reads
  always_comb begin
    new_cnt = rdata;
    if ((func_q == FUNC_PLOT) && (rdata != COUNT_MAX)) begin
      new_cnt = rdata + COUNT_BITS'(1);
    end
  end

  // RAM write: clearing pass or plot write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = new_cnt;
    if (state_q == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if ((state_q == S_MOD) && (func_q == FUNC_PLOT)) begin
      ram_we    = 1'b1;
    end
  end

  cgdp_ram #(
    .AddrW (ADDR_W),
    .DataW (COUNT_BITS)
  ) u_hist (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cell_addr),
    .rdata_o (rdata)
  );

  // halfway move toward the selected vertex
  always_comb begin
    do_move = 1'b1;
    tgt_x   = cfg.vx[0];
    tgt_y   = cfg.vy[0];
    unique case (vsel_e'(sel_q))
      SEL_V0: begin
        tgt_x = cfg.vx[0];
        tgt_y = cfg.vy[0];
      end
      SEL_V1: begin
        tgt_x = cfg.vx[1];
        tgt_y = cfg.vy[1];
      end
      SEL_V2: begin
        tgt_x = cfg.vx[2];
        tgt_y = cfg.vy[2];
      end
      SEL_NONE: do_move = 1'b0;
      default:  do_move = 1'b0;
    endcase
    sum_x = {1'b0, cur_x_q} + {1'b0, tgt_x};
    sum_y = {1'b0, cur_y_q} + {1'b0, tgt_y};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (clr_cnt_q == ADDR_W'(HIST_DEPTH - 1)) state_d = S_IDLE;
      S_IDLE: if (in_acc) state_d = S_READ;
      S_READ: state_d = S_MOD;
      S_MOD:  state_d = S_LVL;
      S_LVL:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
    end
  end

  // cursor and peak state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      peak_q   <= '0;
    end else begin
      if (in_acc && (in_i.data.func == FUNC_PLOT)) begin
        loaded_q <= 1'b1;
        cur_x_q  <= eff_x;
        cur_y_q  <= eff_y;
      end
      if ((state_q == S_MOD) && (func_q == FUNC_PLOT)) begin
        if (new_cnt > peak_q) begin
          peak_q <= new_cnt;
        end
        if (do_move) begin
          cur_x_q <= sum_x[FRAC_BITS:1];
          cur_y_q <= sum_y[FRAC_BITS:1];
        end
      end
    end
  end

  // item capture and counted value
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= in_i.data.func;
      sel_q  <= in_i.data.vertex_select;
      if (in_i.data.func == FUNC_READ) begin
        row_q <= in_i.data.read_row;
        col_q <= in_i.data.read_col;
      end else begin
        row_q <= plot_row;
        col_q <= plot_col;
      end
    end
    if (state_q == S_MOD) begin
      count_q <= new_cnt;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.cell_row      <= row_q;
      out_data_q.cell_col      <= col_q;
      out_data_q.cell_count    <= count_q;
      out_data_q.density_level <= level_of(count_q, peak_q);
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // peak never falls below a count about to be reported
  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LVL) |-> (count_q <= peak_q))
    else $error("peak below reported count");

  // a plot always leaves a nonzero count
  a_plot_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_LVL) && (func_q == FUNC_PLOT)) |-> (count_q != '0))
    else $error("plot left a zero count");

  // level zero exactly when the count is zero
  a_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_data_q.density_level == '0) == (out_data_q.cell_count == '0)))
    else $error("density level disagrees with count");

  // modify step always follows the read step
  a_mod_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |-> $past(state_q == S_READ))
    else $error("modify without preceding read");

endmodule

// ===== hdl/cgdp_ram.sv =====
// ----------------------------------------------------------------------------
// cgdp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cgdp_ram #(
  parameter int AddrW = 14,
  parameter int DataW = 24
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [2**AddrW];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cgdp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cgdp_cfg_regs
// Vertex positions and scaling limits, written through the config port.
// ----------------------------------------------------------------------------
module cgdp_cfg_regs import cgdp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // register writes, reset to the default triangle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vx        <= {16'd58982, 16'd6554, 16'd32768};
      cfg_q.vy        <= {16'd58982, 16'd58982, 16'd6554};
      cfg_q.row_limit <= ROW_W'(63);
      cfg_q.col_limit <= COL_W'(255);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_V0X:  cfg_q.vx[0]     <= cfg_wdata_i[FRAC_BITS-1:0];
        REG_V0Y:  cfg_q.vy[0]     <= cfg_wdata_i[FRAC_BITS-1:0];
        REG_V1X:  cfg_q.vx[1]     <= cfg_wdata_i[FRAC_BITS-1:0];
        REG_V1Y:  cfg_q.vy[1]     <= cfg_wdata_i[FRAC_BITS-1:0];
        REG_V2X:  cfg_q.vx[2]     <= cfg_wdata_i[FRAC_BITS-1:0];
        REG_V2Y:  cfg_q.vy[2]     <= cfg_wdata_i[FRAC_BITS-1:0];
        REG_ROWL: cfg_q.row_limit <= cfg_wdata_i[ROW_W-1:0];
        REG_COLL: cfg_q.col_limit <= cfg_wdata_i[COL_W-1:0];
        default:  cfg_q           <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== tb/tb_chaos_game_density_plotter_core.sv =====
// ----------------------------------------------------------------------------
// tb_chaos_game_density_plotter_core
// Self-checking bench for the chaos game plotter: drives plot and read beats
// under random source gaps and sink stalls, predicts every cell report from a
// shadow cursor, peak and hit-count histogram, and compares each report.
// ----------------------------------------------------------------------------
module tb_chaos_game_density_plotter_core;
  import cgdp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // the quiet limit sits well above the length of the clearing pass after reset
  localparam int unsigned QUIET_LIMIT = 60000;
  localparam int unsigned RECENT_KEEP = 48;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned PHASE_BEATS = 106;
  localparam int unsigned REPORT_MAX  = 10;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  cgdp_in_if  in_bus ();
  cgdp_out_if out_bus ();

  chaos_game_density_plotter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // shadow geometry registers
  logic [FRAC_BITS-1:0]  vert_x [3];
  logic [FRAC_BITS-1:0]  vert_y [3];
  logic [ROW_W-1:0]      lim_row;
  logic [COL_W-1:0]      lim_col;

  // shadow plotting state
  logic [FRAC_BITS-1:0]  cur_x;
  logic [FRAC_BITS-1:0]  cur_y;
  bit                    cur_loaded;
  logic [COUNT_BITS-1:0] peak;
  logic [COUNT_BITS-1:0] hits [HIST_DEPTH];

  out_item_t                   cell_reports_due [$];
  logic [ROW_W+COL_W-1:0]      recent_cells [$];

  bit          src_idle_on  = 1'b1;
  bit          sink_idle_on = 1'b1;
  int unsigned faults       = 0;
  int unsigned plots_sent   = 0;
  int unsigned reads_sent   = 0;
  int unsigned reg_writes   = 0;
  int unsigned settings_run = 0;
  int unsigned quiet_cycles = 0;
  bit [7:0]    levels_seen  = '0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // gap length: mostly short, sometimes medium, rarely long
  function automatic int unsigned pause_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(3, 1);
    if (p < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // shadow state after reset
  function automatic void clear_shadow();
    vert_x[0] = 16'd32768; vert_y[0] = 16'd6554;
    vert_x[1] = 16'd6554;  vert_y[1] = 16'd58982;
    vert_x[2] = 16'd58982; vert_y[2] = 16'd58982;
    lim_row    = ROW_W'(63);
    lim_col    = COL_W'(255);
    cur_x      = '0;
    cur_y      = '0;
    cur_loaded = 1'b0;
    peak       = '0;
    foreach (hits[i]) hits[i] = '0;
  endfunction

  // density grade of a count against the running peak
  function automatic logic [LEVEL_W-1:0] grade(logic [COUNT_BITS-1:0] cnt);
    longint unsigned q;
    if (cnt == '0) return '0;
    if (peak == '0) return LEVEL_W'(5);
    q = (64'(cnt) * 64'd4) / 64'(peak);
    if (q > 64'd4) q = 64'd4;
    return LEVEL_W'(q + 64'd1);
  endfunction

  // fraction times limit, truncated and held inside the grid
  function automatic int unsigned scale_axis(logic [FRAC_BITS-1:0] frac, int unsigned lim,
                                             int unsigned cells);
    longint unsigned v;
    v = (64'(frac) * 64'(lim)) >> FRAC_BITS;
    if (v > 64'(cells - 1)) v = 64'(cells - 1);
    return int'(v);
  endfunction

  // expected cell report for one accepted beat; advances the shadow state
  function automatic out_item_t predict_report(in_item_t it);
    out_item_t             rep;
    int unsigned           r;
    int unsigned           c;
    int unsigned           a;
    logic [COUNT_BITS-1:0] cnt;
    if (it.func == FUNC_READ) begin
      r   = it.read_row;
      c   = it.read_col;
      cnt = (r < GRID_ROWS && c < GRID_COLS) ? hits[r * GRID_COLS + c] : '0;
    end else begin
      if (!cur_loaded) begin
        cur_x      = vert_x[0];
        cur_y      = vert_y[0];
        cur_loaded = 1'b1;
      end
      r = scale_axis(cur_y, lim_row, GRID_ROWS);
      c = scale_axis(cur_x, lim_col, GRID_COLS);
      a = r * GRID_COLS + c;
      if (hits[a] != COUNT_MAX) hits[a] = hits[a] + 1'b1;
      cnt = hits[a];
      if (cnt > peak) peak = cnt;
      recent_cells.push_back({ROW_W'(r), COL_W'(c)});
      if (recent_cells.size() > RECENT_KEEP) void'(recent_cells.pop_front());
      // halfway toward the chosen vertex, rounding down
      if (it.vertex_select != SEL_NONE) begin
        cur_x = FRAC_BITS'(((FRAC_BITS+1)'(cur_x) + (FRAC_BITS+1)'(vert_x[it.vertex_select])) >> 1);
        cur_y = FRAC_BITS'(((FRAC_BITS+1)'(cur_y) + (FRAC_BITS+1)'(vert_y[it.vertex_select])) >> 1);
      end
    end
    rep.cell_row      = ROW_W'(r);
    rep.cell_col      = COL_W'(c);
    rep.cell_count    = cnt;
    rep.density_level = grade(cnt);
    levels_seen[rep.density_level] = 1'b1;
    return rep;
  endfunction

  function automatic in_item_t make_item(func_e f, vsel_e s, logic [ROW_W-1:0] row,
                                         logic [COL_W-1:0] col);
    in_item_t it;
    it.func          = f;
    it.vertex_select = s;
    it.read_row      = row;
    it.read_col      = col;
    return it;
  endfunction

  // mostly plots; reads aim at recently plotted cells more often than not
  function automatic in_item_t random_item();
    in_item_t               it;
    logic [ROW_W+COL_W-1:0] pick;
    it.read_row      = ROW_W'($urandom);
    it.read_col      = COL_W'($urandom);
    it.vertex_select = SEL_W'($urandom);
    if ($urandom_range(99) < 65) begin
      it.func = FUNC_PLOT;
      it.vertex_select = ($urandom_range(9) == 0) ? SEL_NONE : vsel_e'($urandom_range(2));
    end else begin
      it.func = FUNC_READ;
      if (recent_cells.size() != 0 && $urandom_range(99) < 60) begin
        pick        = recent_cells[$urandom_range(recent_cells.size() - 1)];
        it.read_row = pick[ROW_W+COL_W-1:COL_W];
        it.read_col = pick[COL_W-1:0];
      end
    end
    return it;
  endfunction

  function automatic logic [FRAC_BITS-1:0] pick_coord(bit edges_only);
    if (edges_only) return $urandom_range(1) ? '1 : '0;
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return FRAC_BITS'($urandom);
    endcase
  endfunction

  // one input beat: optional gap, then hold valid until taken
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = (src_idle_on && $urandom_range(1) == 1) ? pause_len() : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.data  = it;
    in_bus.valid = 1'b1;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    cell_reports_due.push_back(predict_report(it));
    if (it.func == FUNC_READ) reads_sent++;
    else plots_sent++;
  endtask

  // stop sending and wait for every pending report
  task automatic drain_reports();
    @(negedge clk_i);
    in_bus.valid = 1'b0;
    while (cell_reports_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    case (idx)
      REG_V0X:  vert_x[0] = val;
      REG_V0Y:  vert_y[0] = val;
      REG_V1X:  vert_x[1] = val;
      REG_V1Y:  vert_y[1] = val;
      REG_V2X:  vert_x[2] = val;
      REG_V2Y:  vert_y[2] = val;
      REG_ROWL: lim_row   = val[ROW_W-1:0];
      REG_COLL: lim_col   = val[COL_W-1:0];
    endcase
    reg_writes++;
  endtask

  // full register set, written back to back
  task automatic program_plane(logic [FRAC_BITS-1:0] x0, logic [FRAC_BITS-1:0] y0,
                               logic [FRAC_BITS-1:0] x1, logic [FRAC_BITS-1:0] y1,
                               logic [FRAC_BITS-1:0] x2, logic [FRAC_BITS-1:0] y2,
                               logic [ROW_W-1:0] rl, logic [COL_W-1:0] cl);
    write_reg(REG_V0X, x0);
    write_reg(REG_V0Y, y0);
    write_reg(REG_V1X, x1);
    write_reg(REG_V1Y, y1);
    write_reg(REG_V2X, x2);
    write_reg(REG_V2Y, y2);
    write_reg(REG_ROWL, CFG_DATA_W'(rl));
    write_reg(REG_COLL, CFG_DATA_W'(cl));
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    settings_run++;
  endtask

  task automatic note_fault(string what, out_item_t want, out_item_t got);
    faults++;
    if (faults <= REPORT_MAX)
      $display("[%0t] %s: exp row %0d col %0d count %0d level %0d, got row %0d col %0d count %0d level %0d",
               $time, what, want.cell_row, want.cell_col, want.cell_count, want.density_level,
               got.cell_row, got.cell_col, got.cell_count, got.density_level);
  endtask

  task automatic check_report(out_item_t got);
    out_item_t want;
    if (cell_reports_due.size() == 0) begin
      note_fault("report with nothing pending", '0, got);
      return;
    end
    want = cell_reports_due.pop_front();
    if (got.cell_row !== want.cell_row || got.cell_col !== want.cell_col ||
        got.cell_count !== want.cell_count || got.density_level !== want.density_level)
      note_fault("wrong cell report", want, got);
  endtask

  // result beats
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      check_report(out_bus.data);
  end

  // sink stalls
  initial begin
    int unsigned hold;
    hold = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        out_bus.ready = 1'b0;
      end else if (hold != 0) begin
        out_bus.ready = 1'b0;
        hold--;
      end else if (sink_idle_on && $urandom_range(99) < 30) begin
        out_bus.ready = 1'b0;
        hold = pause_len() - 1;
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("chaos_game_density_plotter_core: mismatch");
    $finish;
  end

  // reset register values; first plot loads the cursor from vertex 0
  task automatic test_reset_defaults();
    send_item(make_item(FUNC_PLOT, SEL_NONE, '1, '1));
    send_item(make_item(FUNC_PLOT, SEL_NONE, '0, '0));
    send_item(make_item(FUNC_PLOT, SEL_V0, '1, '0));
    send_item(make_item(FUNC_PLOT, SEL_V1, '0, '1));
    send_item(make_item(FUNC_PLOT, SEL_V2, '1, '1));
    send_item(make_item(FUNC_PLOT, SEL_V0, '0, '0));
    send_item(make_item(FUNC_READ, SEL_NONE, ROW_W'(6), COL_W'(127)));
    send_item(make_item(FUNC_READ, SEL_V0, '0, '0));
    send_item(make_item(FUNC_READ, SEL_V2, '1, '1));
    send_item(make_item(FUNC_READ, SEL_V1, recent_cells[$][ROW_W+COL_W-1:COL_W],
                        recent_cells[$][COL_W-1:0]));
  endtask

  // zero limits fold every plot onto one cell, then corner vertices at full size
  task automatic test_limit_extremes();
    drain_reports();
    program_plane('0, '0, '1, '1, '1, '0, '0, '0);
    repeat (4) send_item(make_item(FUNC_PLOT, SEL_V1, '1, '1));
    send_item(make_item(FUNC_READ, SEL_V2, '0, '0));
    drain_reports();
    program_plane('0, '0, '1, '1, '1, '0, '1, '1);
    repeat (4) send_item(make_item(FUNC_PLOT, SEL_V1, '0, '0));
    send_item(make_item(FUNC_PLOT, SEL_V2, '1, '0));
    send_item(make_item(FUNC_PLOT, SEL_V0, '0, '1));
    send_item(make_item(FUNC_PLOT, SEL_NONE, '1, '1));
    send_item(make_item(FUNC_READ, SEL_NONE, ROW_W'(62), COL_W'(254)));
  endtask

  // random beats under several register settings
  task automatic test_random_planes();
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_reports();
      case (ph)
        0: program_plane(pick_coord(0), pick_coord(0), pick_coord(0), pick_coord(0),
                         pick_coord(0), pick_coord(0), ROW_W'($urandom), COL_W'($urandom));
        1: program_plane(pick_coord(0), pick_coord(0), pick_coord(0), pick_coord(0),
                         pick_coord(0), pick_coord(0), ROW_W'($urandom_range(4, 1)),
                         COL_W'($urandom_range(4, 1)));
        2: program_plane(pick_coord(1), pick_coord(1), pick_coord(1), pick_coord(1),
                         pick_coord(1), pick_coord(1), '1, COL_W'(1));
        3: program_plane(16'd32768, 16'd6554, 16'd6554, 16'd58982, 16'd58982, 16'd58982,
                         ROW_W'(63), COL_W'(255));
        default: program_plane(pick_coord(0), pick_coord(0), pick_coord(0), pick_coord(0),
                               pick_coord(0), pick_coord(0), ROW_W'($urandom),
                               COL_W'($urandom));
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // occasional stretches with no idling on one or both sides
        if (n % 40 == 0) begin
          src_idle_on  = ($urandom_range(3) != 0);
          sink_idle_on = ($urandom_range(3) != 0);
        end
        send_item(random_item());
      end
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // main sequence
  initial begin
    clear_shadow();
    rst_ni       = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data  = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_V0X;
    cfg_wdata_i  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_limit_extremes();
    test_random_planes();

    drain_reports();
    repeat (20) @(posedge clk_i);
    faults += cell_reports_due.size();

    $display("run covered %0d plot beats and %0d read beats under %0d register settings",
             plots_sent, reads_sent, settings_run + 1);
    $display("%0d register writes, density levels seen (bit per level): %b, %0d faults",
             reg_writes, levels_seen[5:0], faults);
    if (faults == 0) begin
      $display("chaos_game_density_plotter_core: match");
    end else begin
      $display("chaos_game_density_plotter_core: mismatch");
    end
    $finish;
  end

endmodule
